@@ design/h264sfp_pkg.sv @@
`default_nettype none

package h264sfp_pkg;

    // Longest Exp-Golomb prefix accepted by default
    localparam int MAX_LZ_DEFAULT = 31;

    // Profile codes that carry the chroma / bit-depth / scaling fields
    localparam logic [7:0] PROF_HIGH      = 8'd100;
    localparam logic [7:0] PROF_HIGH10    = 8'd110;
    localparam logic [7:0] PROF_HIGH422   = 8'd122;
    localparam logic [7:0] PROF_HIGH444   = 8'd244;
    localparam logic [7:0] PROF_CAVLC444  = 8'd44;
    localparam logic [7:0] PROF_SCALABLE  = 8'd83;
    localparam logic [7:0] PROF_SCAL_HIGH = 8'd86;

    localparam logic [15:0] HEIGHT_PADDED  = 16'd1088;
    localparam logic [15:0] HEIGHT_DISPLAY = 16'd1080;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_OVERLONG = 2'd2;

    // Parse phase: the step counter of the microprogram
    typedef enum logic [4:0] {
        PH_HEADER      = 5'd0,
        PH_SPS_ID      = 5'd1,
        PH_CHROMA      = 5'd2,
        PH_DEPTH_L     = 5'd3,
        PH_DEPTH_C     = 5'd4,
        PH_SCALING     = 5'd5,
        PH_FRAME_NUM   = 5'd6,
        PH_POC_TYPE    = 5'd7,
        PH_POC_LSB     = 5'd8,
        PH_OFF_NONREF  = 5'd9,
        PH_OFF_TB      = 5'd10,
        PH_CYCLE_N     = 5'd11,
        PH_CYCLE_ENTRY = 5'd12,
        PH_MAX_REF     = 5'd13,
        PH_WIDTH       = 5'd14,
        PH_HEIGHT      = 5'd15,
        PH_DONE        = 5'd16
    } phase_t;

    // How the bits of a step are consumed
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_FLAG = 2'd1,
        K_UE   = 2'd2
    } kind_t;

    // What to do when a field completes
    typedef enum logic [3:0] {
        A_NEXT    = 4'd0,
        A_PROFILE = 4'd1,
        A_CHROMA  = 4'd2,
        A_SKIP1   = 4'd3,
        A_POC     = 4'd4,
        A_CYCLE_N = 4'd5,
        A_CYCLE_E = 4'd6,
        A_WIDTH   = 4'd7,
        A_HEIGHT  = 4'd8
    } action_t;

    // One microcode word
    typedef struct packed {
        kind_t   kind;
        action_t act;
        phase_t  nxt;
        phase_t  alt;
        phase_t  alt2;
    } ucw_t;

    // Sequencer to bit datapath
    typedef struct packed {
        logic       step;
        logic       ue;
        logic       clear;
        logic       skip_load;
        logic [3:0] skip_val;
    } eg_cmd_t;

    // Bit datapath to sequencer
    typedef struct packed {
        logic skipping;
        logic done;
        logic overlong;
    } eg_stat_t;

    function automatic logic is_high_profile(input logic [7:0] p);
        return (p == PROF_HIGH) || (p == PROF_HIGH10) || (p == PROF_HIGH422) ||
               (p == PROF_HIGH444) || (p == PROF_CAVLC444) || (p == PROF_SCALABLE) ||
               (p == PROF_SCAL_HIGH);
    endfunction

    // (mbs_minus1 + 1) * 16, forced to all ones when sat is set
    function automatic logic [15:0] mb_to_pixels(input logic sat,
                                                 input logic [11:0] mbs_minus1);
        logic [11:0] mbs;
        mbs = mbs_minus1 + 12'd1;
        return sat ? 16'hFFFF : {mbs, 4'd0};
    endfunction

endpackage

`default_nettype wire

@@ design/h264sfp_ucode.sv @@
`default_nettype none

module h264sfp_ucode
    import h264sfp_pkg::*;
(
    input  wire phase_t phase,
    output ucw_t        uw
);

    // Control store: one word per parse step
    always_comb
    begin
        unique case (phase)
            PH_HEADER:      uw = '{K_NONE, A_NEXT,    PH_HEADER,      PH_HEADER,      PH_HEADER};
            PH_SPS_ID:      uw = '{K_UE,   A_PROFILE, PH_FRAME_NUM,   PH_CHROMA,      PH_HEADER};
            PH_CHROMA:      uw = '{K_UE,   A_CHROMA,  PH_DEPTH_L,     PH_HEADER,      PH_HEADER};
            PH_DEPTH_L:     uw = '{K_UE,   A_NEXT,    PH_DEPTH_C,     PH_HEADER,      PH_HEADER};
            PH_DEPTH_C:     uw = '{K_UE,   A_SKIP1,   PH_SCALING,     PH_HEADER,      PH_HEADER};
            PH_SCALING:     uw = '{K_FLAG, A_NEXT,    PH_FRAME_NUM,   PH_HEADER,      PH_HEADER};
            PH_FRAME_NUM:   uw = '{K_UE,   A_NEXT,    PH_POC_TYPE,    PH_HEADER,      PH_HEADER};
            PH_POC_TYPE:    uw = '{K_UE,   A_POC,     PH_MAX_REF,     PH_POC_LSB,     PH_OFF_NONREF};
            PH_POC_LSB:     uw = '{K_UE,   A_NEXT,    PH_MAX_REF,     PH_HEADER,      PH_HEADER};
            PH_OFF_NONREF:  uw = '{K_UE,   A_NEXT,    PH_OFF_TB,      PH_HEADER,      PH_HEADER};
            PH_OFF_TB:      uw = '{K_UE,   A_NEXT,    PH_CYCLE_N,     PH_HEADER,      PH_HEADER};
            PH_CYCLE_N:     uw = '{K_UE,   A_CYCLE_N, PH_MAX_REF,     PH_CYCLE_ENTRY, PH_HEADER};
            PH_CYCLE_ENTRY: uw = '{K_UE,   A_CYCLE_E, PH_MAX_REF,     PH_CYCLE_ENTRY, PH_HEADER};
            PH_MAX_REF:     uw = '{K_UE,   A_SKIP1,   PH_WIDTH,       PH_HEADER,      PH_HEADER};
            PH_WIDTH:       uw = '{K_UE,   A_WIDTH,   PH_HEIGHT,      PH_HEADER,      PH_HEADER};
            PH_HEIGHT:      uw = '{K_UE,   A_HEIGHT,  PH_DONE,        PH_HEADER,      PH_HEADER};
            PH_DONE:        uw = '{K_NONE, A_NEXT,    PH_DONE,        PH_DONE,        PH_DONE};
            default:        uw = '{K_NONE, A_NEXT,    PH_DONE,        PH_DONE,        PH_DONE};
        endcase
    end

endmodule

`default_nettype wire

@@ design/h264sfp_egdp.sv @@
`default_nettype none

module h264sfp_egdp
    import h264sfp_pkg::*;
#(
    parameter  int MAX_LEADING_ZEROS = MAX_LZ_DEFAULT,
    localparam int LZ_W  = $clog2(MAX_LEADING_ZEROS + 1),
    localparam int ACC_W = MAX_LEADING_ZEROS,
    localparam int VAL_W = MAX_LEADING_ZEROS + 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             bit_in,
    input  wire eg_cmd_t          cmd,
    output eg_stat_t              stat,
    output logic [VAL_W-1:0]      value
);

    logic [LZ_W-1:0]  lz_reg, lz_next;
    logic [LZ_W-1:0]  left_reg, left_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [3:0]       skip_reg, skip_next;

    logic [ACC_W-1:0] acc_shift;
    logic [VAL_W-1:0] ones;
    logic             active;

    // Decode the current bit against prefix/suffix state
    always_comb
    begin
        acc_shift = {acc_reg[ACC_W-2:0], bit_in};
        ones      = (VAL_W'(1) << lz_reg) - VAL_W'(1);
        value     = (left_reg == '0) ? '0 : ones + VAL_W'(acc_shift);

        stat.skipping = (skip_reg != 4'd0);
        active        = cmd.ue && !stat.skipping;
        stat.overlong = active && (left_reg == '0) && !bit_in &&
                        (lz_reg >= LZ_W'(MAX_LEADING_ZEROS));
        stat.done     = active && (((left_reg == '0) && bit_in && (lz_reg == '0)) ||
                                   (left_reg == LZ_W'(1)));
    end

    // Advance prefix count, suffix shift and skip counter
    always_comb
    begin
        lz_next   = lz_reg;
        left_next = left_reg;
        acc_next  = acc_reg;
        skip_next = skip_reg;
        if (cmd.clear)
        begin
            lz_next   = '0;
            left_next = '0;
            acc_next  = '0;
            skip_next = 4'd0;
        end
        else
        begin
            if (cmd.skip_load)
                skip_next = cmd.skip_val;
            else if (cmd.step && stat.skipping)
                skip_next = skip_reg - 4'd1;

            if (cmd.step && active)
            begin
                if (left_reg == '0)
                begin
                    if (!bit_in)
                    begin
                        if (!stat.overlong)
                            lz_next = lz_reg + LZ_W'(1);
                    end
                    else if (lz_reg != '0)
                    begin
                        left_next = lz_reg;
                        acc_next  = '0;
                    end
                end
                else
                begin
                    acc_next  = acc_shift;
                    left_next = left_reg - LZ_W'(1);
                    if (left_reg == LZ_W'(1))
                    begin
                        lz_next  = '0;
                        acc_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lz_reg   <= '0;
            left_reg <= '0;
            acc_reg  <= '0;
            skip_reg <= 4'd0;
        end
        else
        begin
            lz_reg   <= lz_next;
            left_reg <= left_next;
            acc_reg  <= acc_next;
            skip_reg <= skip_next;
        end
    end

endmodule

`default_nettype wire

@@ design/h264_sps_frame_size_parser.sv @@
// H.264 SPS frame-size parser.
// Input channel (in_valid/in_ready): one SPS byte per beat, NAL header byte
// first; last_byte marks the final byte of the unit and rearms the parser.
// Output channel (out_valid/out_ready): at most one beat per SPS carrying
// width_pixels, height_pixels, profile_code and status (ok, truncated,
// prefix too long). The beat leaves once the height code completes, on an
// overlong prefix, or at the last byte if neither happened.
// The four header bytes are taken in the idle state; a later byte is accepted,
// then its 8 bits are stepped one per cycle through the Exp-Golomb bit unit
// under the microcode sequencer, pausing while a result waits for the output
// slot; stepping ends at the bit that places a result, and once a result is
// placed each later byte is accepted and dropped. last_byte adds the S_LAST
// rearm step. out_valid is registered from the bit that completes the result;
// a truncation result is placed in S_LAST, after the last byte is done.
// The output register holds a result while the receiver stalls; parsing
// continues until the sequencer needs to place another result, and then
// waits for the slot to free.
// Reset clears the sequencer, the bit unit and the output valid; the parser
// then expects a NAL header byte.
`default_nettype none

module h264_sps_frame_size_parser
    import h264sfp_pkg::*;
#(
    parameter int MAX_LEADING_ZEROS = MAX_LZ_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  sps_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      width_pixels,
    output logic [15:0]      height_pixels,
    output logic [7:0]       profile_code,
    output logic [1:0]       status
);

    localparam int VAL_W = MAX_LEADING_ZEROS + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_BITS = 2'd1,
        S_LAST = 2'd2
    } state_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  profile_reg, profile_next;
    logic        c444_reg, c444_next;
    logic [7:0]  poc_left_reg, poc_left_next;
    logic [15:0] width_reg, width_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bitcnt_reg, bitcnt_next;
    logic        last_reg, last_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_width_reg, out_width_next;
    logic [15:0] out_height_reg, out_height_next;
    logic [7:0]  out_profile_reg, out_profile_next;
    logic [1:0]  out_status_reg, out_status_next;

    ucw_t             uw;
    eg_cmd_t          cmd;
    eg_stat_t         stat;
    logic [VAL_W-1:0] value;

    logic        bit_cur;
    logic        slot_free;
    logic        want_emit;
    logic        emit;
    logic [15:0] emit_height;
    logic [1:0]  emit_status;
    logic        size_sat;
    logic [15:0] size_px;

    h264sfp_ucode u_ucode (
        .phase (phase_reg),
        .uw    (uw)
    );

    h264sfp_egdp #(
        .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
    ) u_egdp (
        .clk    (clk),
        .rst_n  (rst_n),
        .bit_in (bit_cur),
        .cmd    (cmd),
        .stat   (stat),
        .value  (value)
    );

    assign bit_cur   = byte_reg[7];
    assign slot_free = !out_valid_reg || out_ready;

    // Size of a completed width/height code
    assign size_sat = (|value[VAL_W-1:12]) || (&value[11:0]);
    assign size_px  = mb_to_pixels(size_sat, value[11:0]);

    // Sequencer: step through bytes and bits, apply the microcode word
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        profile_next  = profile_reg;
        c444_next     = c444_reg;
        poc_left_next = poc_left_reg;
        width_next    = width_reg;
        byte_next     = byte_reg;
        bitcnt_next   = bitcnt_reg;
        last_next     = last_reg;
        in_ready      = (state_reg == S_IDLE);
        cmd           = '0;
        want_emit     = 1'b0;
        emit          = 1'b0;
        emit_height   = 16'd0;
        emit_status   = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = last_byte;
                    if (phase_reg == PH_HEADER)
                    begin
                        if (hdr_cnt_reg == 3'd1)
                            profile_next = sps_byte;
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                        if (hdr_cnt_reg == 3'd3)
                            phase_next = PH_SPS_ID;
                        state_next = last_byte ? S_LAST : S_IDLE;
                    end
                    else
                    begin
                        byte_next   = sps_byte;
                        bitcnt_next = 3'd0;
                        state_next  = S_BITS;
                    end
                end
            end

            S_BITS:
            begin
                if (phase_reg == PH_DONE || phase_reg == PH_HEADER)
                begin
                    // drop the rest of the byte
                    state_next = last_reg ? S_LAST : S_IDLE;
                end
                else
                begin
                    cmd.ue    = (uw.kind == K_UE);
                    want_emit = stat.overlong || (stat.done && uw.act == A_HEIGHT);
                    if (!want_emit || slot_free)
                    begin
                        cmd.step    = 1'b1;
                        byte_next   = {byte_reg[6:0], 1'b0};
                        bitcnt_next = bitcnt_reg + 3'd1;
                        if (bitcnt_reg == 3'd7)
                            state_next = last_reg ? S_LAST : S_IDLE;

                        if (!stat.skipping)
                        begin
                            if (uw.kind == K_FLAG)
                            begin
                                // scaling lists present: step over their flags
                                if (bit_cur)
                                begin
                                    cmd.skip_load = 1'b1;
                                    cmd.skip_val  = c444_reg ? 4'd12 : 4'd8;
                                end
                                phase_next = uw.nxt;
                            end
                            else if (stat.overlong)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_OVERLONG;
                            end
                            else if (stat.done)
                            begin
                                unique case (uw.act)
                                    A_NEXT:
                                        phase_next = uw.nxt;
                                    A_PROFILE:
                                        phase_next = is_high_profile(profile_reg) ?
                                                     uw.alt : uw.nxt;
                                    A_CHROMA:
                                    begin
                                        c444_next = (value == VAL_W'(3));
                                        if (value == VAL_W'(3))
                                        begin
                                            cmd.skip_load = 1'b1;
                                            cmd.skip_val  = 4'd1;
                                        end
                                        phase_next = uw.nxt;
                                    end
                                    A_SKIP1:
                                    begin
                                        cmd.skip_load = 1'b1;
                                        cmd.skip_val  = 4'd1;
                                        phase_next    = uw.nxt;
                                    end
                                    A_POC:
                                    begin
                                        if (value == '0)
                                            phase_next = uw.alt;
                                        else if (value == VAL_W'(1))
                                        begin
                                            cmd.skip_load = 1'b1;
                                            cmd.skip_val  = 4'd1;
                                            phase_next    = uw.alt2;
                                        end
                                        else
                                            phase_next = uw.nxt;
                                    end
                                    A_CYCLE_N:
                                    begin
                                        poc_left_next = (|value[VAL_W-1:8]) ?
                                                        8'hFF : value[7:0];
                                        phase_next    = (value != '0) ? uw.alt : uw.nxt;
                                    end
                                    A_CYCLE_E:
                                    begin
                                        if (poc_left_reg != 8'd0)
                                            poc_left_next = poc_left_reg - 8'd1;
                                        if (poc_left_reg <= 8'd1)
                                            phase_next = uw.nxt;
                                    end
                                    A_WIDTH:
                                    begin
                                        width_next = size_px;
                                        phase_next = uw.nxt;
                                    end
                                    A_HEIGHT:
                                    begin
                                        emit        = 1'b1;
                                        emit_status = ST_OK;
                                        emit_height = (size_px == HEIGHT_PADDED) ?
                                                      HEIGHT_DISPLAY : size_px;
                                    end
                                    default:
                                        phase_next = PH_DONE;
                                endcase
                            end
                        end

                        if (emit)
                        begin
                            phase_next = PH_DONE;
                            state_next = last_reg ? S_LAST : S_IDLE;
                        end
                    end
                end
            end

            S_LAST:
            begin
                want_emit = (phase_reg != PH_DONE);
                if (!want_emit || slot_free)
                begin
                    emit          = want_emit;
                    emit_status   = ST_TRUNC;
                    // rearm for the next SPS
                    cmd.clear     = 1'b1;
                    phase_next    = PH_HEADER;
                    hdr_cnt_next  = 3'd0;
                    profile_next  = 8'd0;
                    c444_next     = 1'b0;
                    poc_left_next = 8'd0;
                    width_next    = 16'd0;
                    state_next    = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register: load on a result, drop once taken
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_width_next   = out_width_reg;
        out_height_next  = out_height_reg;
        out_profile_next = out_profile_reg;
        out_status_next  = out_status_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_width_next   = width_reg;
            out_height_next  = emit_height;
            out_profile_next = profile_reg;
            out_status_next  = emit_status;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Hold sequencer state, byte shifter and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_HEADER;
            hdr_cnt_reg     <= 3'd0;
            profile_reg     <= 8'd0;
            c444_reg        <= 1'b0;
            poc_left_reg    <= 8'd0;
            width_reg       <= 16'd0;
            byte_reg        <= 8'd0;
            bitcnt_reg      <= 3'd0;
            last_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_width_reg   <= 16'd0;
            out_height_reg  <= 16'd0;
            out_profile_reg <= 8'd0;
            out_status_reg  <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            profile_reg     <= profile_next;
            c444_reg        <= c444_next;
            poc_left_reg    <= poc_left_next;
            width_reg       <= width_next;
            byte_reg        <= byte_next;
            bitcnt_reg      <= bitcnt_next;
            last_reg        <= last_next;
            out_valid_reg   <= out_valid_next;
            out_width_reg   <= out_width_next;
            out_height_reg  <= out_height_next;
            out_profile_reg <= out_profile_next;
            out_status_reg  <= out_status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign width_pixels  = out_width_reg;
    assign height_pixels = out_height_reg;
    assign profile_code  = out_profile_reg;
    assign status        = out_status_reg;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
module testbench
    import h264sfp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ZEROS      = MAX_LZ_DEFAULT;
    localparam int STALL_LIMIT    = 3000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RANDOM_BYTES   = 460;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic [7:0] EXT_PROFILES [0:6] = '{PROF_HIGH, PROF_HIGH10, PROF_HIGH422,
        PROF_HIGH444, PROF_CAVLC444, PROF_SCALABLE, PROF_SCAL_HIGH};

    // Shapes of generated SPS units
    typedef enum int {
        UNIT_CLEAN    = 0,
        UNIT_CUT      = 1,
        UNIT_OVERLONG = 2,
        UNIT_NOISE    = 3
    } unit_kind_t;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  profile;
        logic [1:0]  status;
    } frame_size_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  sps_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] width_pixels;
    logic [15:0] height_pixels;
    logic [7:0]  profile_code;
    logic [1:0]  status;

    h264_sps_frame_size_parser #(
        .MAX_LEADING_ZEROS(MAX_ZEROS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sps_byte      (sps_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .width_pixels  (width_pixels),
        .height_pixels (height_pixels),
        .profile_code  (profile_code),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run bookkeeping
    int error_count   = 0;
    int bytes_sent    = 0;
    int units_sent    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int rx_hold_left  = 0;
    bit idle_on       = 1'b1;
    int unit_mix [4]  = '{0, 0, 0, 0};
    int status_mix [4] = '{0, 0, 0, 0};

    // ------------------------------------------------------------------
    // Frame-size predictor
    // ------------------------------------------------------------------
    phase_t          sps_phase;
    int unsigned     hdr_seen;
    logic [7:0]      sps_profile;
    bit              sps_444;
    int unsigned     zero_run;
    longint unsigned suffix_val;
    int unsigned     suffix_left;
    int unsigned     cycle_left;
    int unsigned     skip_left;
    logic [15:0]     sps_width;
    bit              sps_reported;

    frame_size_t frame_size_q [$];

    function automatic void clear_parser();
        sps_phase    = PH_HEADER;
        hdr_seen     = 0;
        sps_profile  = 8'd0;
        sps_444      = 1'b0;
        zero_run     = 0;
        suffix_val   = 0;
        suffix_left  = 0;
        cycle_left   = 0;
        skip_left    = 0;
        sps_width    = 16'd0;
        sps_reported = 1'b0;
    endfunction

    function automatic bit is_extended_profile(logic [7:0] p);
        return p inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444,
                         PROF_CAVLC444, PROF_SCALABLE, PROF_SCAL_HIGH};
    endfunction

    function automatic logic [15:0] mbs_to_pixels(longint unsigned code);
        longint unsigned px;
        px = (code + 1) * 16;
        return (px > 65535) ? 16'hFFFF : px[15:0];
    endfunction

    // Queue a frame-size beat and stop parsing until the last byte
    function automatic void queue_frame_size(logic [15:0] h, logic [1:0] st);
        frame_size_q.push_back('{width: sps_width, height: h, profile: sps_profile,
                                 status: st});
        sps_reported = 1'b1;
        sps_phase    = PH_DONE;
    endfunction

    // Act on a completed Exp-Golomb field; return 1 when a beat is queued
    function automatic bit finish_field(longint unsigned v);
        logic [15:0] h;
        case (sps_phase)
            PH_SPS_ID:
                sps_phase = is_extended_profile(sps_profile) ? PH_CHROMA : PH_FRAME_NUM;
            PH_CHROMA:
            begin
                sps_444 = (v == 3);
                if (sps_444)
                    skip_left = 1;
                sps_phase = PH_DEPTH_L;
            end
            PH_DEPTH_L:
                sps_phase = PH_DEPTH_C;
            PH_DEPTH_C:
            begin
                skip_left = 1;
                sps_phase = PH_SCALING;
            end
            PH_FRAME_NUM:
                sps_phase = PH_POC_TYPE;
            PH_POC_TYPE:
            begin
                if (v == 0)
                    sps_phase = PH_POC_LSB;
                else if (v == 1)
                begin
                    skip_left = 1;
                    sps_phase = PH_OFF_NONREF;
                end
                else
                    sps_phase = PH_MAX_REF;
            end
            PH_POC_LSB:
                sps_phase = PH_MAX_REF;
            PH_OFF_NONREF:
                sps_phase = PH_OFF_TB;
            PH_OFF_TB:
                sps_phase = PH_CYCLE_N;
            PH_CYCLE_N:
            begin
                cycle_left = (v > 255) ? 255 : v[7:0];
                sps_phase = (cycle_left != 0) ? PH_CYCLE_ENTRY : PH_MAX_REF;
            end
            PH_CYCLE_ENTRY:
            begin
                if (cycle_left != 0)
                    cycle_left--;
                if (cycle_left == 0)
                    sps_phase = PH_MAX_REF;
            end
            PH_MAX_REF:
            begin
                skip_left = 1;
                sps_phase = PH_WIDTH;
            end
            PH_WIDTH:
            begin
                sps_width = mbs_to_pixels(v);
                sps_phase = PH_HEIGHT;
            end
            PH_HEIGHT:
            begin
                h = mbs_to_pixels(v);
                if (h == HEIGHT_PADDED)
                    h = HEIGHT_DISPLAY;
                queue_frame_size(h, ST_OK);
                return 1'b1;
            end
            default:
                sps_phase = PH_DONE;
        endcase
        return 1'b0;
    endfunction

    // Consume one bitstream bit, MSB first
    function automatic bit shift_in_bit(bit b);
        longint unsigned v;
        if (sps_phase == PH_DONE || sps_phase == PH_HEADER)
            return 1'b0;
        if (skip_left != 0)
        begin
            skip_left--;
            return 1'b0;
        end
        if (sps_phase == PH_SCALING)
        begin
            if (b)
                skip_left = sps_444 ? 12 : 8;
            sps_phase = PH_FRAME_NUM;
            return 1'b0;
        end
        if (suffix_left == 0)
        begin
            if (!b)
            begin
                if (zero_run >= MAX_ZEROS)
                begin
                    queue_frame_size(16'd0, ST_OVERLONG);
                    return 1'b1;
                end
                zero_run++;
                return 1'b0;
            end
            if (zero_run != 0)
            begin
                suffix_left = zero_run;
                suffix_val  = 0;
                return 1'b0;
            end
            v = 0;
        end
        else
        begin
            suffix_val = (suffix_val << 1) | b;
            suffix_left--;
            if (suffix_left != 0)
                return 1'b0;
            v = ((64'd1 << zero_run) - 1) + suffix_val;
        end
        zero_run   = 0;
        suffix_val = 0;
        return finish_field(v);
    endfunction

    function automatic void predict_sps_beat(logic [7:0] b, logic last);
        bit got;
        got = 1'b0;
        if (sps_phase == PH_HEADER)
        begin
            if (hdr_seen == 1)
                sps_profile = b;
            hdr_seen++;
            if (hdr_seen >= 4)
                sps_phase = PH_SPS_ID;
        end
        else
        begin
            for (int i = 7; i >= 0 && !got; i--)
                got = shift_in_bit(b[i]);
        end
        // Rearm on the last byte, flagging a unit that never reached the height
        if (last)
        begin
            if (!sps_reported && !got)
                queue_frame_size(16'd0, ST_TRUNC);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // SPS unit generator
    // ------------------------------------------------------------------
    bit         stream_bits [$];
    logic [7:0] unit_bytes [$];

    function automatic void put_ue(longint unsigned v);
        longint unsigned c;
        int n;
        c = v + 1;
        n = 0;
        while ((c >> (n + 1)) != 0)
            n++;
        repeat (n) stream_bits.push_back(1'b0);
        for (int i = n; i >= 0; i--)
            stream_bits.push_back(c[i]);
    endfunction

    function automatic void put_random_bits(int unsigned count);
        repeat (count) stream_bits.push_back(1'($urandom));
    endfunction

    function automatic longint unsigned random_size_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 67;
        if (r < 70)
            return $urandom_range(0, 130);
        if (r < 88)
            return $urandom_range(131, 600);
        if (r < 96)
            return $urandom_range(4090, 4100);
        return $urandom_range(32'hFFFF_FFFE);
    endfunction

    // Header bytes plus the field sequence up to the height code
    function automatic void compose_sps(logic [7:0] prof, int unsigned chroma, bit scaling,
                                        int unsigned poc_type, int unsigned cycle_n,
                                        longint unsigned w_code, longint unsigned h_code);
        int unsigned entries;
        stream_bits.delete();
        unit_bytes.delete();
        unit_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h67);
        unit_bytes.push_back(prof);
        unit_bytes.push_back(8'($urandom));
        unit_bytes.push_back(8'($urandom));
        put_ue($urandom_range(0, 31));
        if (is_extended_profile(prof))
        begin
            put_ue(chroma);
            if (chroma == 3)
                put_random_bits(1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_random_bits(1);
            stream_bits.push_back(scaling);
            if (scaling)
                put_random_bits((chroma == 3) ? 12 : 8);
        end
        put_ue($urandom_range(0, 12));
        put_ue(poc_type);
        if (poc_type == 0)
            put_ue($urandom_range(0, 12));
        else if (poc_type == 1)
        begin
            put_random_bits(1);
            put_ue($urandom_range(0, 40));
            put_ue($urandom_range(0, 40));
            put_ue(cycle_n);
            entries = (cycle_n > 255) ? 255 : cycle_n;
            repeat (entries) put_ue($urandom_range(0, 2));
        end
        put_ue($urandom_range(0, 16));
        put_random_bits(1);
        put_ue(w_code);
        put_ue(h_code);
    endfunction

    function automatic void compose_random_sps();
        logic [7:0] prof;
        int unsigned chroma;
        int unsigned poc_type;
        int unsigned cycle_n;
        int unsigned r;
        prof = ($urandom_range(0, 1) == 0) ? EXT_PROFILES[$urandom_range(0, 6)]
                                           : 8'($urandom);
        chroma = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(4, 20);
        r = $urandom_range(0, 99);
        poc_type = (r < 40) ? 0 : (r < 70) ? 1 : (r < 90) ? 2 : $urandom_range(3, 10);
        r = $urandom_range(0, 99);
        cycle_n = (r < 85) ? $urandom_range(0, 4) :
                  (r < 97) ? $urandom_range(5, 30) : $urandom_range(256, 300);
        compose_sps(prof, chroma, 1'($urandom), poc_type, cycle_n,
                    random_size_code(), random_size_code());
    endfunction

    // Append trailing bits, pad to a byte boundary and pack MSB first
    function automatic void seal_unit(int unsigned extra);
        logic [7:0] b;
        put_random_bits(extra);
        while (stream_bits.size() % 8 != 0)
            put_random_bits(1);
        for (int i = 0; i < stream_bits.size(); i += 8)
        begin
            for (int k = 0; k < 8; k++)
                b[7 - k] = stream_bits[i + k];
            unit_bytes.push_back(b);
        end
    endfunction

    function automatic void make_random_unit(unit_kind_t kind);
        int unsigned keep;
        case (kind)
            UNIT_CLEAN:
            begin
                compose_random_sps();
                seal_unit($urandom_range(0, 24));
            end
            UNIT_CUT:
            begin
                compose_random_sps();
                seal_unit(0);
                keep = $urandom_range(1, unit_bytes.size() - 1);
                while (unit_bytes.size() > keep)
                    void'(unit_bytes.pop_back());
            end
            UNIT_OVERLONG:
            begin
                compose_random_sps();
                keep = $urandom_range(0, stream_bits.size());
                while (stream_bits.size() > keep)
                    void'(stream_bits.pop_back());
                repeat ($urandom_range(32, 40)) stream_bits.push_back(1'b0);
                seal_unit($urandom_range(0, 16));
            end
            default:
            begin
                unit_bytes.delete();
                repeat ($urandom_range(1, 16)) unit_bytes.push_back(8'($urandom));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver, checker, watchdog
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sps_byte  <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_unit();
        for (int i = 0; i < unit_bytes.size(); i++)
            send_beat(unit_bytes[i], i == unit_bytes.size() - 1);
        units_sent++;
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (frame_size_q.size() != 0)
            @(posedge clk);
    endtask

    // Drive out_ready: forced low during a hold-off, else random stalls while idle_on is set
    always @(negedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else
            out_ready <= !(idle_on && $urandom_range(0, 99) < 14);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Check the output beat first, then predict from the input beat
    always @(posedge clk)
    begin
        frame_size_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                status_mix[status]++;
                if (frame_size_q.size() == 0)
                    report_mismatch($sformatf("unexpected beat %0d x %0d profile %0d status %0d",
                        width_pixels, height_pixels, profile_code, status));
                else
                begin
                    want = frame_size_q.pop_front();
                    check_field("width_pixels", width_pixels, want.width);
                    check_field("height_pixels", height_pixels, want.height);
                    check_field("profile_code", profile_code, want.profile);
                    check_field("status", status, want.status);
                end
            end
            if (in_valid && in_ready)
                predict_sps_beat(sps_byte, last_byte);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, frame_size_q.size());
                $display("** h264_sps_frame_size_parser: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Units that end inside the header bytes
    task automatic test_header_truncation();
        unit_bytes = '{8'hFF};
        send_unit();
        unit_bytes = '{8'h00, 8'hFF};
        send_unit();
        unit_bytes = '{8'h67, 8'h00, 8'h00, 8'h00};
        send_unit();
    endtask

    // Baseline profile, POC type 2, 1920 x 1088 reported as 1080
    task automatic test_baseline_1080();
        compose_sps(8'd66, 0, 1'b0, 2, 0, 119, 67);
        seal_unit(0);
        send_unit();
    endtask

    // 4:4:4 high profile with scaling flags, POC type 1, widest width code
    task automatic test_high_444_scaling();
        compose_sps(PROF_HIGH444, 3, 1'b1, 1, 2, 64'hFFFF_FFFE, 0);
        seal_unit(0);
        send_unit();
    endtask

    // 32 zeros in the first field prefix, then an ignored byte
    task automatic test_overlong_prefix();
        unit_bytes = '{8'h67, PROF_HIGH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_unit();
    endtask

    task automatic test_random_units();
        unit_kind_t kind;
        int unsigned r;
        int n;
        n = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            // one long stretch with no idling on either side
            idle_on = !(n >= 15 && n < 23);
            r = $urandom_range(0, 99);
            kind = (r < 55) ? UNIT_CLEAN : (r < 70) ? UNIT_CUT :
                   (r < 85) ? UNIT_OVERLONG : UNIT_NOISE;
            make_random_unit(kind);
            send_unit();
            unit_mix[kind]++;
            n++;
        end
        idle_on = 1'b1;
    endtask

    // Cycle count above 255 saturates
    task automatic test_poc_cycle_saturation();
        compose_sps(8'd77, 0, 1'b0, 1, 256 + $urandom_range(0, 40), 100, 50);
        seal_unit(0);
        send_unit();
    endtask

    // Hold the receiver off while units keep coming so the input stalls
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        hold_input();
        rx_hold_left = HOLDOFF_CYCLES;
        repeat (4)
        begin
            make_random_unit(UNIT_CLEAN);
            send_unit();
            unit_mix[UNIT_CLEAN]++;
        end
        idle_on = 1'b1;
    endtask

    // Sender pauses until every pending result has left
    task automatic test_drain_pause();
        make_random_unit(UNIT_CLEAN);
        send_unit();
        hold_input();
        wait_results_drained();
        make_random_unit(UNIT_CUT);
        send_unit();
        unit_mix[UNIT_CLEAN]++;
        unit_mix[UNIT_CUT]++;
    endtask

    initial
    begin
        clear_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_header_truncation();
        test_baseline_1080();
        test_high_444_scaling();
        test_overlong_prefix();
        test_random_units();
        test_poc_cycle_saturation();
        test_output_backpressure();
        test_drain_pause();

        hold_input();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d SPS units in %0d bytes", units_sent, bytes_sent);
        $display("  random mix: %0d clean, %0d cut, %0d overlong, %0d noise",
                 unit_mix[UNIT_CLEAN], unit_mix[UNIT_CUT],
                 unit_mix[UNIT_OVERLONG], unit_mix[UNIT_NOISE]);
        $display("Checked %0d frame-size beats: %0d ok, %0d truncated, %0d overlong",
                 results_seen, status_mix[ST_OK], status_mix[ST_TRUNC],
                 status_mix[ST_OVERLONG]);
        $display("  %0d mismatches", error_count);
        if (error_count == 0)
            $display("** h264_sps_frame_size_parser: PASSED **");
        else
            $display("** h264_sps_frame_size_parser: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
design/h264sfp_pkg.sv
design/h264sfp_ucode.sv
design/h264sfp_egdp.sv
design/h264_sps_frame_size_parser.sv
dv/testbench.sv
